// File: src/mprq_pkg.sv
// ----------------------------------------------------------------------------
// mprq_pkg
// shared types, constants and the ordering compare for the ready queue
// ----------------------------------------------------------------------------
package mprq_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int MAX_PRIORITY = 4;
	localparam int IDX_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] MODE_FIFO = 3'd0;
	localparam logic [2:0] MODE_LCFS = 3'd1;
	localparam logic [2:0] MODE_SRT  = 3'd2;
	localparam logic [2:0] MODE_RR   = 3'd3;
	localparam logic [2:0] MODE_PRIO = 3'd4;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_GET = 1'b1;

	typedef struct packed {
		logic [7:0]        id;
		logic [31:0]       stamp;
		logic [15:0]       rem;
		logic [2:0]        stat;
		logic signed [2:0] dyn;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	function automatic logic better(input logic [2:0] mode, input entry_t a, input entry_t b);
		logic r;
		unique case (mode)
			MODE_LCFS: r = a.stamp > b.stamp;
			MODE_SRT:  r = (a.rem != b.rem) ? (a.rem < b.rem) : (a.stamp < b.stamp);
			MODE_PRIO: r = (a.dyn != b.dyn) ? (a.dyn > b.dyn) : (a.stamp < b.stamp);
			default:   r = a.stamp < b.stamp;
		endcase
		return r;
	endfunction

endpackage

// File: src/mprq_cell.sv
// ----------------------------------------------------------------------------
// mprq_cell
// one slot of both banks; passes the running best candidate to its neighbor
// ----------------------------------------------------------------------------
module mprq_cell import mprq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [2:0]       mode,
	input  logic             wr,
	input  logic             wr_bank,
	input  entry_t           wr_entry,
	input  logic             clr,
	input  logic             clr_bank,
	input  logic             bank_sel,
	input  logic             step,
	input  logic             best_vld_in,
	input  entry_t           best_in,
	input  logic [IDX_W-1:0] best_idx_in,
	input  logic [IDX_W-1:0] my_idx,
	output logic             best_vld_out,
	output entry_t           best_out,
	output logic [IDX_W-1:0] best_idx_out,
	output logic [1:0]       valid
);
	entry_t     ent_q [2];
	logic [1:0] vld_q;
	logic       take;

	assign valid = vld_q;
	assign take  = vld_q[bank_sel] && (!best_vld_in || better(mode, ent_q[bank_sel], best_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (wr) vld_q[wr_bank] <= 1'b1;
			if (clr) vld_q[clr_bank] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) ent_q[wr_bank] <= wr_entry;
	end

	// pass-on registers of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_out <= 1'b0;
		end else if (step) begin
			best_vld_out <= best_vld_in || vld_q[bank_sel];
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			best_out     <= take ? ent_q[bank_sel] : best_in;
			best_idx_out <= take ? my_idx : best_idx_in;
		end
	end
endmodule

// File: src/multi_policy_ready_queue_unit.sv
// ----------------------------------------------------------------------------
// multi_policy_ready_queue_unit
// two-bank ready queue with fifo, lcfs, srt, rr (ordered as fifo) and priority selection
// ----------------------------------------------------------------------------
//  channel | signals                           | direction
//  in      | in_valid, in_stall, op..from_preempt | into block
//  out     | out_valid, out_stall, ok..dropped_full | out of block
//  cfg     | cfg_we, cfg_wdata (mode)          | into block
//
//  an add result is valid the cycle after its transfer in
//  a get ripples the best candidate through the chain of QUEUE_DEPTH cells,
//  one cell per cycle, then clears the winning slot and registers the result
//  one item at a time; in_stall is high while an item is in flight or its
//  result waits; reset clears valid bits, counts and bank select
module multi_policy_ready_queue_unit import mprq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [7:0]        task_id,
	input  logic [31:0]       ready_stamp,
	input  logic [15:0]       remaining_time,
	input  logic [2:0]        static_prio,
	input  logic signed [2:0] dynamic_prio,
	input  logic              from_preempt,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic [7:0]        out_task_id,
	output logic [15:0]       out_remaining,
	output logic signed [2:0] out_dynamic,
	output logic [2:0]        out_static,
	output logic [31:0]       out_stamp,
	output logic              to_expired,
	output logic              banks_swapped,
	output logic [4:0]        active_count,
	output logic [4:0]        expired_count,
	output logic              dropped_full
);
	logic [2:0]   mode_q;
	state_t       state_q, state_d;
	logic         act_q;
	logic [CNT_W-1:0] cnt_q [2];
	logic [IDX_W:0]   step_q;
	logic             swp_q;

	logic [QUEUE_DEPTH-1:0] vbank [2];
	logic [1:0]   cvalid [QUEUE_DEPTH];
	logic         bv [QUEUE_DEPTH+1];
	entry_t       be [QUEUE_DEPTH+1];
	logic [IDX_W-1:0] bi [QUEUE_DEPTH+1];

	logic         accept, add, target, full;
	entry_t       ne;
	logic signed [3:0] s1, dm1;
	logic [IDX_W-1:0] free_idx;
	logic         stepping, clr;
	logic         sel;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_FIFO;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	for (genvar c = 0; c < QUEUE_DEPTH; c++) begin : g_v
		assign vbank[0][c] = cvalid[c][0];
		assign vbank[1][c] = cvalid[c][1];
	end

	// new entry for an add
	always_comb begin
		s1  = $signed({1'b0, static_prio}) - 4'sd1;
		if (s1 > 4'(MAX_PRIORITY - 1)) s1 = 4'(MAX_PRIORITY - 1);
		dm1 = 4'(dynamic_prio) - 4'sd1;
		ne.id = task_id;
		ne.stamp = ready_stamp;
		ne.rem = remaining_time;
		ne.stat = static_prio;
		ne.dyn = dynamic_prio;
		target = act_q;
		if (mode_q == MODE_PRIO) begin
			if (!from_preempt) ne.dyn = s1[2:0];
			else if (dm1 >= 0) ne.dyn = dm1[2:0];
			else begin
				ne.dyn = s1[2:0];
				target = !act_q;
			end
		end
		free_idx = '0;
		for (int k = QUEUE_DEPTH - 1; k >= 0; k--)
			if (!vbank[target][k]) free_idx = IDX_W'(k);
		full = &vbank[target];
	end

	assign add = accept && op == OP_ADD && !full;
	assign sel = (accept && cnt_q[act_q] == '0 && cnt_q[!act_q] != '0) ? !act_q : act_q;
	assign stepping = (state_q == ST_SCAN) && (step_q != (IDX_W+1)'(QUEUE_DEPTH));
	assign clr = (state_q == ST_SCAN) && !stepping && bv[QUEUE_DEPTH];

	assign bv[0] = 1'b0;
	assign be[0] = '0;
	assign bi[0] = '0;

	for (genvar c = 0; c < QUEUE_DEPTH; c++) begin : g_cell
		mprq_cell u_cell (
			.clk, .arst_n,
			.mode(mode_q),
			.wr(add && free_idx == IDX_W'(c)),
			.wr_bank(target),
			.wr_entry(ne),
			.clr(clr && bi[QUEUE_DEPTH] == IDX_W'(c)),
			.clr_bank(act_q),
			.bank_sel(act_q),
			.step(stepping),
			.best_vld_in(bv[c]),
			.best_in(be[c]),
			.best_idx_in(bi[c]),
			.my_idx(IDX_W'(c)),
			.best_vld_out(bv[c+1]),
			.best_out(be[c+1]),
			.best_idx_out(bi[c+1]),
			.valid(cvalid[c])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = (op == OP_GET) ? ST_SCAN : ST_DONE;
			ST_SCAN: if (!stepping) state_d = ST_DONE;
			ST_DONE: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q   <= 1'b0;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			step_q  <= '0;
			swp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && op == OP_GET) begin
				act_q  <= sel;
				swp_q  <= sel != act_q;
				step_q <= '0;
			end else if (stepping) begin
				step_q <= step_q + 1'b1;
			end
			if (add) cnt_q[target] <= cnt_q[target] + 1'b1;
			if (clr) cnt_q[act_q] <= cnt_q[act_q] - 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept && op == OP_ADD) begin
			ok            <= !full;
			out_task_id   <= '0;
			out_remaining <= '0;
			out_dynamic   <= ne.dyn;
			out_static    <= '0;
			out_stamp     <= '0;
			to_expired    <= !full && target != act_q;
			banks_swapped <= 1'b0;
			dropped_full  <= full;
			active_count  <= 5'(add && target == act_q ? cnt_q[act_q] + 1'b1 : cnt_q[act_q]);
			expired_count <= 5'(add && target != act_q ? cnt_q[!act_q] + 1'b1 : cnt_q[!act_q]);
		end else if (state_q == ST_SCAN && !stepping) begin
			ok            <= bv[QUEUE_DEPTH];
			out_task_id   <= bv[QUEUE_DEPTH] ? be[QUEUE_DEPTH].id : '0;
			out_remaining <= bv[QUEUE_DEPTH] ? be[QUEUE_DEPTH].rem : '0;
			out_dynamic   <= bv[QUEUE_DEPTH] ? be[QUEUE_DEPTH].dyn : '0;
			out_static    <= bv[QUEUE_DEPTH] ? be[QUEUE_DEPTH].stat : '0;
			out_stamp     <= bv[QUEUE_DEPTH] ? be[QUEUE_DEPTH].stamp : '0;
			to_expired    <= 1'b0;
			banks_swapped <= swp_q;
			dropped_full  <= 1'b0;
			active_count  <= 5'(bv[QUEUE_DEPTH] ? cnt_q[act_q] - 1'b1 : cnt_q[act_q]);
			expired_count <= 5'(cnt_q[!act_q]);
		end
	end

`ifndef SYNTH
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("take while busy");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CNT_W'(QUEUE_DEPTH) && cnt_q[1] <= CNT_W'(QUEUE_DEPTH))
		else $error("count overflow");
	a_cnt_pop: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> cnt_q[act_q] == $past(cnt_q[act_q]) - 1'b1) else $error("pop count");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok)) else $error("result lost");
`endif
endmodule
